// ===== sv/circular_list_with_cursor_macros.svh =====
// Assertion macros shared by the circular list RTL
`ifndef CIRCULAR_LIST_WITH_CURSOR_MACROS_SVH
`define CIRCULAR_LIST_WITH_CURSOR_MACROS_SVH

// Check a condition at every clock edge outside reset
`define CLC_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Check that a condition in one cycle implies another in the next
`define CLC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/clc_pkg.sv =====
// Shared types and constants of the circular list with cursor
`timescale 1ns / 1ps

package clc_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int VAL_W = 32;
   localparam int OP_W = 3;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND  = 3'd0,
      OP_INSERT  = 3'd1,
      OP_HEAD    = 3'd2,
      OP_ADVANCE = 3'd3,
      OP_REMOVE  = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_NOCUR = 2'd3
   } status_type;

   typedef struct packed {
      logic [VAL_W-1:0] value;
      status_type       status;
      logic [CNT_W-1:0] count;
   } result_type;

endpackage

// ===== sv/circular_list_with_cursor.sv =====
// Top level of the circular list with cursor: sequencer, node stores, free stack
//
// Usage:
//   Requests enter on req_*: req_tuser carries the opcode (append at tail,
//   insert at head, cursor to head, advance cursor, remove cursor node),
//   req_tdata the element to store. Each request gives exactly one response
//   on rsp_*: element read or removed, status and the element count.
//   Sequence: a request that fails its checks (or an unused opcode) is
//   answered from idle; remove passes S_REM, append or insert into an empty
//   list S_INS; cursor to head and advance pass S_HOP then S_VAL, and append
//   or insert into a non-empty list S_INS then S_INS2. The steps follow the
//   link store, which takes one read and one write a cycle: a hop reads a
//   link and then the value it points at, and an insert writes two links in turn.
//   Requests are taken one at a time; req_tready is high while the
//   sequencer is idle, also while a finished response still waits.
//   Reset empties the list, unplaces the cursor and refills the free stack
//   at once through per-entry valid bits, so no clearing pass is needed.
//   When the receiver stalls, the response stays in the output register;
//   a later result is parked until the register frees, and the sequencer
//   holds in the meantime.
`timescale 1ns / 1ps
`include "circular_list_with_cursor_macros.svh"

module circular_list_with_cursor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value_in
   input  logic [2:0]  req_tuser,   // [2:0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] value_out, [36:32] element_count, zero above
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   localparam int IW = clc_pkg::IDX_W;
   localparam int CW = clc_pkg::CNT_W;
   localparam int VW = clc_pkg::VAL_W;
   localparam int CAP = clc_pkg::CAPACITY;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_INS  = 7'b0000010,
      S_INS2 = 7'b0000100,
      S_HOP  = 7'b0001000,
      S_VAL  = 7'b0010000,
      S_REM  = 7'b0100000,
      S_DONE = 7'b1000000
   } state_type;

   // Sequencer and list registers
   state_type              state_ff, state_in;
   clc_pkg::opcode_type    op_ff, op_in;
   logic [VW-1:0]          val_ff, val_in;
   logic [CW-1:0]          free_top_ff, free_top_in;
   logic [IW-1:0]          tail_ff, tail_in;
   logic                   nonempty_ff, nonempty_in;
   logic [IW-1:0]          cursor_ff, cursor_in;
   logic [IW-1:0]          prior_ff, prior_in;
   logic                   placed_ff, placed_in;
   logic                   prior_known_ff, prior_known_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [IW-1:0]          n_ff, n_in;
   logic [IW-1:0]          lt_ff, lt_in;
   clc_pkg::result_type    pend_ff, pend_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   clc_pkg::result_type    rsp_res_ff, rsp_res_in;

   // Memories and their registered read data
   logic [VW-1:0]          value_mem [CAP];
   logic [IW-1:0]          link_mem  [CAP];
   logic [IW-1:0]          fs_mem    [CAP];
   logic [CAP-1:0]         fs_valid_ff;
   logic [VW-1:0]          val_rd_ff;
   logic [IW-1:0]          link_rd_ff;
   logic [IW-1:0]          fs_rd_ff;

   // Memory controls
   logic [IW-1:0]          val_raddr, link_raddr, fs_raddr;
   logic                   val_we, link_we, fs_we;
   logic [IW-1:0]          val_waddr, link_waddr, fs_waddr;
   logic [IW-1:0]          link_wdata, fs_wdata;

   clc_pkg::opcode_type    req_op;
   clc_pkg::result_type    res_c;
   logic                   finish;
   logic                   out_free;
   logic [IW-1:0]          n_c;

   assign req_op = clc_pkg::opcode_type'(req_tuser);
   assign req_tready = (state_ff == S_IDLE);
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Read addresses: hops follow the link just read
   always_comb begin
      if (req_op inside {clc_pkg::OP_ADVANCE, clc_pkg::OP_REMOVE}) begin
         link_raddr = cursor_ff;
      end else begin
         link_raddr = tail_ff;
      end
      val_raddr = (state_ff == S_HOP) ? link_rd_ff : cursor_ff;
      fs_raddr = IW'(free_top_ff - CW'(1));
   end

   // Sequence one request
   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      val_in         = val_ff;
      free_top_in    = free_top_ff;
      tail_in        = tail_ff;
      nonempty_in    = nonempty_ff;
      cursor_in      = cursor_ff;
      prior_in       = prior_ff;
      placed_in      = placed_ff;
      prior_known_in = prior_known_ff;
      count_in       = count_ff;
      n_in           = n_ff;
      lt_in          = lt_ff;
      pend_in        = pend_ff;
      finish         = 1'b0;
      res_c.value    = '0;
      res_c.status   = clc_pkg::ST_OK;
      res_c.count    = count_ff;
      val_we         = 1'b0;
      val_waddr      = '0;
      link_we        = 1'b0;
      link_waddr     = '0;
      link_wdata     = '0;
      fs_we          = 1'b0;
      fs_waddr       = '0;
      fs_wdata       = '0;
      n_c            = fs_rd_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in  = req_op;
               val_in = req_tdata;
               case (req_op)
                  clc_pkg::OP_APPEND, clc_pkg::OP_INSERT: begin
                     if (free_top_ff == '0) begin
                        res_c.status = clc_pkg::ST_FULL;
                        finish = 1'b1;
                     end else begin
                        state_in = S_INS;
                     end
                  end
                  clc_pkg::OP_HEAD: begin
                     if (!nonempty_ff) begin
                        res_c.status = clc_pkg::ST_EMPTY;
                        finish = 1'b1;
                     end else begin
                        state_in = S_HOP;
                     end
                  end
                  clc_pkg::OP_ADVANCE: begin
                     if (!nonempty_ff) begin
                        res_c.status = clc_pkg::ST_EMPTY;
                        finish = 1'b1;
                     end else if (!placed_ff) begin
                        res_c.status = clc_pkg::ST_NOCUR;
                        finish = 1'b1;
                     end else begin
                        state_in = S_HOP;
                     end
                  end
                  clc_pkg::OP_REMOVE: begin
                     if (!nonempty_ff) begin
                        res_c.status = clc_pkg::ST_EMPTY;
                        finish = 1'b1;
                     end else if (!placed_ff || !prior_known_ff) begin
                        res_c.status = clc_pkg::ST_NOCUR;
                        finish = 1'b1;
                     end else begin
                        state_in = S_REM;
                     end
                  end
                  default: begin
                     finish = 1'b1;
                  end
               endcase
            end
         end
         S_INS: begin
            // Pop a node, store the element, hook it after the tail
            val_we      = 1'b1;
            val_waddr   = n_c;
            link_we     = 1'b1;
            link_waddr  = nonempty_ff ? tail_ff : n_c;
            link_wdata  = n_c;
            n_in        = n_c;
            lt_in       = link_rd_ff;
            free_top_in = free_top_ff - CW'(1);
            count_in    = count_ff + CW'(1);
            if (placed_ff && prior_known_ff && prior_ff == tail_ff) begin
               prior_in = n_c;
            end
            if (!nonempty_ff) begin
               tail_in     = n_c;
               nonempty_in = 1'b1;
               finish      = 1'b1;
            end else begin
               if (op_ff == clc_pkg::OP_APPEND) begin
                  tail_in = n_c;
               end
               state_in = S_INS2;
            end
         end
         S_INS2: begin
            // Close the ring through the new node
            link_we    = 1'b1;
            link_waddr = n_ff;
            link_wdata = lt_ff;
            finish     = 1'b1;
         end
         S_HOP: begin
            // Step the cursor; the value read follows next cycle
            prior_in       = (op_ff == clc_pkg::OP_HEAD) ? tail_ff : cursor_ff;
            cursor_in      = link_rd_ff;
            placed_in      = 1'b1;
            prior_known_in = 1'b1;
            state_in       = S_VAL;
         end
         S_VAL: begin
            res_c.value = val_rd_ff;
            finish = 1'b1;
         end
         S_REM: begin
            // Unlink the cursor node and push it back on the free stack
            res_c.value = val_rd_ff;
            if (count_ff <= CW'(1) || link_rd_ff == cursor_ff) begin
               nonempty_in    = 1'b0;
               placed_in      = 1'b0;
               prior_known_in = 1'b0;
               tail_in        = '0;
               cursor_in      = '0;
               prior_in       = '0;
            end else begin
               if (cursor_ff == tail_ff) begin
                  tail_in = prior_ff;
               end
               link_we        = 1'b1;
               link_waddr     = prior_ff;
               link_wdata     = link_rd_ff;
               cursor_in      = prior_ff;
               prior_known_in = 1'b0;
            end
            if (free_top_ff < CW'(CAP)) begin
               fs_we       = 1'b1;
               fs_waddr    = IW'(free_top_ff);
               fs_wdata    = cursor_ff;
               free_top_in = free_top_ff + CW'(1);
            end
            if (count_ff != '0) begin
               count_in = count_ff - CW'(1);
            end
            finish = 1'b1;
         end
         S_DONE: begin
            finish = 1'b1;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (state_ff == S_DONE) begin
         res_c = pend_ff;
      end else begin
         res_c.count = count_in;
      end

      // Hand the result over, or park it while the receiver stalls
      if (finish) begin
         if (out_free) begin
            state_in = S_IDLE;
         end else begin
            state_in = S_DONE;
            pend_in  = res_c;
         end
      end
   end

   // Output register
   always_comb begin
      rsp_res_in = rsp_res_ff;
      if (finish && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = res_c;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_res_ff.count, rsp_res_ff.value};
   assign rsp_tuser  = rsp_res_ff.status;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         free_top_ff    <= CW'(CAP);
         tail_ff        <= '0;
         nonempty_ff    <= 1'b0;
         cursor_ff      <= '0;
         prior_ff       <= '0;
         placed_ff      <= 1'b0;
         prior_known_ff <= 1'b0;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         fs_valid_ff    <= '0;
      end else begin
         state_ff       <= state_in;
         free_top_ff    <= free_top_in;
         tail_ff        <= tail_in;
         nonempty_ff    <= nonempty_in;
         cursor_ff      <= cursor_in;
         prior_ff       <= prior_in;
         placed_ff      <= placed_in;
         prior_known_ff <= prior_known_in;
         count_ff       <= count_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (fs_we) begin
            fs_valid_ff[fs_waddr] <= 1'b1;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      val_ff     <= val_in;
      n_ff       <= n_in;
      lt_ff      <= lt_in;
      pend_ff    <= pend_in;
      rsp_res_ff <= rsp_res_in;
   end

   // Node value store
   always_ff @(posedge clock) begin
      if (val_we) begin
         value_mem[val_waddr] <= val_ff;
      end
      val_rd_ff <= value_mem[val_raddr];
   end

   // Node link store
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      link_rd_ff <= link_mem[link_raddr];
   end

   // Free stack; an entry never pushed reads as its own index
   always_ff @(posedge clock) begin
      if (fs_we) begin
         fs_mem[fs_waddr] <= fs_wdata;
      end
      fs_rd_ff <= fs_valid_ff[fs_raddr] ? fs_mem[fs_raddr] : fs_raddr;
   end

   `CLC_ASSERT_ALWAYS(a_pool_balance, (free_top_ff + count_ff) == CW'(CAP), "free plus held is not capacity")
   `CLC_ASSERT_ALWAYS(a_nonempty_count, nonempty_ff == (count_ff != '0), "nonempty flag disagrees with count")
   `CLC_ASSERT_ALWAYS(a_cursor_in_list, !placed_ff || nonempty_ff, "cursor placed on an empty list")
   `CLC_ASSERT_NEXT(a_accept_moves, req_tvalid && req_tready, (state_ff != S_IDLE) || rsp_valid_ff, "accepted request left no trace")

endmodule
